// ===== rtl/core/gil_pkg.sv =====
// ----------------------------------------------------------------------------
// gil_pkg: shared types and constants for the glyph index lookup core
// Request codes, queue item layout and the configuration register bundle.
// ----------------------------------------------------------------------------
package gil_pkg;

	localparam int CODE_W  = 21;
	localparam int GLYPH_W = 24;
	localparam int SLOT_W  = 10;
	localparam int REQ_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int AR_W = 7;
	localparam int AS_W = 11;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [REQ_W-1:0] REQ_LOOKUP    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WR_RANGE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WR_SPARSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RANGES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SPARSE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GLYPH_TOTAL = 2'd2;

	typedef enum logic [1:0] {
		OP_LOOKUP    = 2'd0,
		OP_WR_RANGE  = 2'd1,
		OP_WR_SPARSE = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] last;
	} item_t;

	typedef struct packed {
		logic [AR_W-1:0]    active_ranges;
		logic [AS_W-1:0]    active_sparse;
		logic [GLYPH_W-1:0] range_glyph_total;
	} cfg_t;

endpackage

// ===== rtl/core/gil_front.sv =====
// ----------------------------------------------------------------------------
// gil_front: request intake and classification
// Registers each request beat, drops requests that have no effect and hands
// the rest to the queue as operations.
// ----------------------------------------------------------------------------
module gil_front #(
	parameter int MAX_RANGES = 64,
	parameter int MAX_SPARSE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gil_pkg::REQ_W-1:0]     req_type,
	input  logic [gil_pkg::SLOT_W-1:0]    slot,
	input  logic [gil_pkg::CODE_W-1:0]    code_point,
	input  logic [gil_pkg::CODE_W-1:0]    range_last,
	output logic                          push_valid,
	input  logic                          push_ready,
	output gil_pkg::item_t                push_item
);

	logic           valid_s1;
	gil_pkg::item_t item_s1;
	logic           keep;
	gil_pkg::op_t   op;
	logic           accept;
	logic [31:0]    slot_ext;

	assign slot_ext = 32'(slot);

	always_comb begin
		keep = 1'b0;
		op   = gil_pkg::OP_LOOKUP;
		unique case (req_type)
			gil_pkg::REQ_LOOKUP: begin
				keep = 1'b1;
				op   = gil_pkg::OP_LOOKUP;
			end
			gil_pkg::REQ_WR_RANGE: begin
				keep = (slot_ext < 32'(MAX_RANGES));
				op   = gil_pkg::OP_WR_RANGE;
			end
			gil_pkg::REQ_WR_SPARSE: begin
				keep = (slot_ext < 32'(MAX_SPARSE));
				op   = gil_pkg::OP_WR_SPARSE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall   = valid_s1 & ~push_ready;
	assign accept     = in_valid & ~in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= op;
			item_s1.slot <= slot;
			item_s1.code <= code_point;
			item_s1.last <= range_last;
		end
	end

endmodule

// ===== rtl/core/gil_fifo.sv =====
// ----------------------------------------------------------------------------
// gil_fifo: short operation queue
// Decouples the front from the back so that each side can stall on its own.
// ----------------------------------------------------------------------------
module gil_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  gil_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop,
	output gil_pkg::item_t pop_item
);

	localparam int DEPTH = gil_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gil_pkg::item_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/gil_back.sv =====
// ----------------------------------------------------------------------------
// gil_back: table store and lookup sequencer
// Executes table writes, scans the range table one entry per cycle and then
// binary searches the sparse table one probe per cycle.
// ----------------------------------------------------------------------------
module gil_back #(
	parameter int MAX_RANGES = 64,
	parameter int MAX_SPARSE = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gil_pkg::cfg_t                cfg,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  gil_pkg::item_t               q_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [gil_pkg::GLYPH_W-1:0]  glyph_idx
);

	localparam int CW  = gil_pkg::CODE_W;
	localparam int GW  = gil_pkg::GLYPH_W;
	localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RKW = $clog2(MAX_RANGES + 1);
	localparam int SIW = (MAX_SPARSE > 1) ? $clog2(MAX_SPARSE) : 1;
	localparam int SKW = $clog2(MAX_SPARSE + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RSCAN  = 4'b0010,
		ST_SPROBE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	function automatic logic [SKW-1:0] mid_of(input logic [SKW-1:0] lo,
	                                          input logic [SKW-1:0] hiex);
		logic [SKW-1:0] span;
		span = hiex - SKW'(1) - lo;
		return lo + (span >> 1);
	endfunction

	logic [CW-1:0] rf_mem [MAX_RANGES];
	logic [CW-1:0] rl_mem [MAX_RANGES];
	logic [CW-1:0] sp_mem [MAX_SPARSE];
	logic [CW-1:0] rf_rd_q;
	logic [CW-1:0] rl_rd_q;
	logic [CW-1:0] sp_rd_q;

	state_t         state_q, state_d;
	logic [CW-1:0]  code_q, code_d;
	logic [GW-1:0]  acc_q, acc_d;
	logic [RKW-1:0] k_q, k_d;
	logic [SKW-1:0] lo_q, lo_d;
	logic [SKW-1:0] hi_q, hi_d;
	logic [SKW-1:0] mid_q, mid_d;
	logic           res_found_q, res_found_d;
	logic [GW-1:0]  res_idx_q, res_idx_d;
	logic           out_valid_q;
	logic           out_found_q;
	logic [GW-1:0]  out_idx_q;

	logic [RKW-1:0] nr;
	logic [SKW-1:0] ns;
	logic [RKW-1:0] k_inc;
	logic [SKW-1:0] lo_n;
	logic [SKW-1:0] hi_n;
	logic [RIW-1:0] r_addr;
	logic [SIW-1:0] s_addr;
	logic [31:0]    slot_ext;
	logic           r_we;
	logic           s_we;
	logic           go_sparse;
	logic           load_out;

	// Counts beyond the table depth saturate to the depth.
	assign nr = (32'(cfg.active_ranges) > 32'(MAX_RANGES)) ? RKW'(MAX_RANGES)
	                                                      : RKW'(cfg.active_ranges);
	assign ns = (32'(cfg.active_sparse) > 32'(MAX_SPARSE)) ? SKW'(MAX_SPARSE)
	                                                      : SKW'(cfg.active_sparse);
	assign k_inc    = k_q + RKW'(1);
	assign slot_ext = 32'(q_item.slot);

	always_comb begin
		state_d     = state_q;
		code_d      = code_q;
		acc_d       = acc_q;
		k_d         = k_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		res_found_d = res_found_q;
		res_idx_d   = res_idx_q;
		lo_n        = lo_q;
		hi_n        = hi_q;
		r_addr      = '0;
		s_addr      = mid_q[SIW-1:0];
		q_pop       = 1'b0;
		r_we        = 1'b0;
		s_we        = 1'b0;
		go_sparse   = 1'b0;
		load_out    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						gil_pkg::OP_LOOKUP: begin
							code_d = q_item.code;
							acc_d  = '0;
							k_d    = '0;
							if (nr == '0) begin
								go_sparse = 1'b1;
							end else begin
								state_d = ST_RSCAN;
							end
						end
						gil_pkg::OP_WR_RANGE: begin
							r_we = 1'b1;
						end
						gil_pkg::OP_WR_SPARSE: begin
							s_we = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RSCAN: begin
				if (code_q >= rf_rd_q && code_q <= rl_rd_q) begin
					res_found_d = 1'b1;
					res_idx_d   = acc_q + GW'(code_q - rf_rd_q);
					state_d     = ST_EMIT;
				end else begin
					// A reversed range still adds its wrapped length.
					acc_d = acc_q + (GW'(rl_rd_q) - GW'(rf_rd_q)) + GW'(1);
					if (k_inc == nr) begin
						go_sparse = 1'b1;
					end else begin
						k_d    = k_inc;
						r_addr = k_inc[RIW-1:0];
					end
				end
			end
			ST_SPROBE: begin
				if (sp_rd_q == code_q) begin
					res_found_d = 1'b1;
					res_idx_d   = cfg.range_glyph_total + GW'(mid_q);
					state_d     = ST_EMIT;
				end else begin
					if (sp_rd_q < code_q) begin
						lo_n = mid_q + SKW'(1);
					end else begin
						hi_n = mid_q;
					end
					lo_d = lo_n;
					hi_d = hi_n;
					if (lo_n >= hi_n) begin
						res_found_d = 1'b0;
						res_idx_d   = '0;
						state_d     = ST_EMIT;
					end else begin
						mid_d  = mid_of(lo_n, hi_n);
						s_addr = mid_d[SIW-1:0];
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (go_sparse) begin
			lo_d = '0;
			hi_d = ns;
			if (ns == '0) begin
				res_found_d = 1'b0;
				res_idx_d   = '0;
				state_d     = ST_EMIT;
			end else begin
				mid_d   = mid_of('0, ns);
				s_addr  = mid_d[SIW-1:0];
				state_d = ST_SPROBE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			rf_mem[slot_ext[RIW-1:0]] <= q_item.code;
			rl_mem[slot_ext[RIW-1:0]] <= q_item.last;
		end
		rf_rd_q <= rf_mem[r_addr];
		rl_rd_q <= rl_mem[r_addr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			sp_mem[slot_ext[SIW-1:0]] <= q_item.code;
		end
		sp_rd_q <= sp_mem[s_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q      <= code_d;
		acc_q       <= acc_d;
		k_q         <= k_d;
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		mid_q       <= mid_d;
		res_found_q <= res_found_d;
		res_idx_q   <= res_idx_d;
		if (load_out) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign glyph_idx = out_idx_q;

endmodule

// ===== rtl/core/glyph_index_lookup_core.sv =====
// ----------------------------------------------------------------------------
// glyph_index_lookup_core: code point to glyph index lookup
// Range table scan followed by a sparse table binary search.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    req_type, slot, code_point, range_last
//   out      out_valid / out_stall  found, glyph_idx
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// In the back sequencer a lookup scans the range table (one range table read
// per cycle) and, on a miss, probes the sparse table (one sparse memory read
// per cycle, at most ceil(log2(active_sparse + 1)) probes). Reset clears only
// control state and the configuration registers; the tables need no
// clearing pass. Requests keep entering through the front stage and queue
// while the back works or a result beat waits in the output register, until
// the queue and the front stage are full.
// ----------------------------------------------------------------------------
module glyph_index_lookup_core #(
	parameter int MAX_RANGES = 64,
	parameter int MAX_SPARSE = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gil_pkg::REQ_W-1:0]         req_type,
	input  logic [gil_pkg::SLOT_W-1:0]        slot,
	input  logic [gil_pkg::CODE_W-1:0]        code_point,
	input  logic [gil_pkg::CODE_W-1:0]        range_last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [gil_pkg::GLYPH_W-1:0]       glyph_idx,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gil_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gil_pkg::CFG_DATA_W-1:0]    cfg_data
);

	gil_pkg::cfg_t  cfg_q;
	logic           push_valid;
	logic           push_ready;
	gil_pkg::item_t push_item;
	logic           q_valid;
	logic           q_pop;
	gil_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gil_pkg::CFG_ACTIVE_RANGES: begin
					cfg_q.active_ranges <= cfg_data[gil_pkg::AR_W-1:0];
				end
				gil_pkg::CFG_ACTIVE_SPARSE: begin
					cfg_q.active_sparse <= cfg_data[gil_pkg::AS_W-1:0];
				end
				gil_pkg::CFG_RANGE_GLYPH_TOTAL: begin
					cfg_q.range_glyph_total <= cfg_data[gil_pkg::GLYPH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	gil_front #(
		.MAX_RANGES (MAX_RANGES),
		.MAX_SPARSE (MAX_SPARSE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.slot       (slot),
		.code_point (code_point),
		.range_last (range_last),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	gil_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	gil_back #(
		.MAX_RANGES (MAX_RANGES),
		.MAX_SPARSE (MAX_SPARSE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.glyph_idx   (glyph_idx)
	);

endmodule

// ===== tb/sv/glyph_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_lookup_checker: result predictor and scoreboard for the lookup core
// Watches the request, result and register channels, keeps its own copy of
// the range and sparse tables and of the registers, and compares every
// result beat with the answer worked out for the oldest waiting lookup.
// ----------------------------------------------------------------------------
module glyph_lookup_checker #(
	parameter int MAX_RANGES = 64,
	parameter int MAX_SPARSE = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [gil_pkg::REQ_W-1:0]      req_type,
	input  logic [gil_pkg::SLOT_W-1:0]     slot,
	input  logic [gil_pkg::CODE_W-1:0]     code_point,
	input  logic [gil_pkg::CODE_W-1:0]     range_last,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           found,
	input  logic [gil_pkg::GLYPH_W-1:0]    glyph_idx,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gil_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gil_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             backlog,
	output int                             beats_checked
);

	localparam int CW  = gil_pkg::CODE_W;
	localparam int GW  = gil_pkg::GLYPH_W;
	localparam int ARW = gil_pkg::AR_W;
	localparam int ASW = gil_pkg::AS_W;

	typedef struct packed {
		logic          hit;
		logic [GW-1:0] glyph;
	} glyph_answer_t;

	logic [CW-1:0]  range_first_q [MAX_RANGES];
	logic [CW-1:0]  range_last_q [MAX_RANGES];
	logic [CW-1:0]  sparse_q [MAX_SPARSE];
	logic [ARW-1:0] ranges_in_use;
	logic [ASW-1:0] sparse_in_use;
	logic [GW-1:0]  sparse_base;

	glyph_answer_t answers_due [$];
	int errs = 0;
	int checked = 0;

	assign mismatches = errs;
	assign beats_checked = checked;

	// Range scan with a running glyph count, then a binary search of the
	// sparse codes. Counts above the table depth saturate to the depth.
	function automatic glyph_answer_t resolve_code(input logic [CW-1:0] code);
		glyph_answer_t ans;
		int nr, ns, lo, hi, mid, k;
		logic [GW-1:0] run;
		ans = '0;
		run = '0;
		nr = (int'(ranges_in_use) > MAX_RANGES) ? MAX_RANGES : int'(ranges_in_use);
		ns = (int'(sparse_in_use) > MAX_SPARSE) ? MAX_SPARSE : int'(sparse_in_use);
		for (k = 0; k < nr && !ans.hit; k++) begin
			if (code >= range_first_q[k] && code <= range_last_q[k]) begin
				ans.hit = 1'b1;
				ans.glyph = run + GW'(code - range_first_q[k]);
			end else begin
				// A reversed range still adds its wrapped length.
				run = run + GW'(range_last_q[k]) - GW'(range_first_q[k]) + GW'(1);
			end
		end
		lo = 0;
		hi = ns - 1;
		while (!ans.hit && lo <= hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (sparse_q[mid] == code) begin
				ans.hit = 1'b1;
				ans.glyph = sparse_base + GW'(mid);
			end else if (sparse_q[mid] < code) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		glyph_answer_t oldest;
		if (!arst_n) begin
			ranges_in_use = '0;
			sparse_in_use = '0;
			sparse_base = '0;
			answers_due.delete();
			backlog <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gil_pkg::CFG_ACTIVE_RANGES: ranges_in_use = cfg_data[ARW-1:0];
					gil_pkg::CFG_ACTIVE_SPARSE: sparse_in_use = cfg_data[ASW-1:0];
					gil_pkg::CFG_RANGE_GLYPH_TOTAL: sparse_base = cfg_data[GW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					errs++;
					$display(
						"%0t: unexpected beat, expected none, actual found %0b glyph 0x%06h",
						$time, found, glyph_idx);
				end else begin
					oldest = answers_due.pop_front();
					checked++;
					if (found !== oldest.hit) begin
						errs++;
						$display("%0t: found mismatch, expected %0b, actual %0b",
							$time, oldest.hit, found);
					end
					if (glyph_idx !== oldest.glyph) begin
						errs++;
						$display("%0t: glyph_idx mismatch, expected 0x%06h, actual 0x%06h",
							$time, oldest.glyph, glyph_idx);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					gil_pkg::REQ_WR_RANGE: begin
						if (slot < MAX_RANGES) begin
							range_first_q[slot] = code_point;
							range_last_q[slot] = range_last;
						end
					end
					gil_pkg::REQ_WR_SPARSE: begin
						if (slot < MAX_SPARSE)
							sparse_q[slot] = code_point;
					end
					gil_pkg::REQ_LOOKUP: answers_due.push_back(resolve_code(code_point));
					default: ;
				endcase
			end
			backlog <= answers_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for glyph_index_lookup_core
// Loads range and sparse tables through write requests, programs the
// registers between phases, and sends directed and random lookups under
// changing sender and receiver idling; the checker scores every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int REQ_W = gil_pkg::REQ_W;
	localparam int SLOT_W = gil_pkg::SLOT_W;
	localparam int CODE_W = gil_pkg::CODE_W;
	localparam int GLYPH_W = gil_pkg::GLYPH_W;
	localparam int CFG_IDX_W = gil_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gil_pkg::CFG_DATA_W;
	localparam int AR_W = gil_pkg::AR_W;
	localparam int AS_W = gil_pkg::AS_W;
	localparam int MAX_RANGES = 64;
	localparam int MAX_SPARSE = 1024;
	localparam int CLK_HALF = 10;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_ITEMS = 1350;
	localparam int CODE_SPACE = 2097152;
	localparam int CODE_TOP = 2097151;
	localparam int GLYPH_TOP = 16777215;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type = gil_pkg::REQ_LOOKUP;
	logic [SLOT_W-1:0]     slot = '0;
	logic [CODE_W-1:0]     code_point = '0;
	logic [CODE_W-1:0]     range_last = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  found;
	logic [GLYPH_W-1:0]    glyph_idx;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = gil_pkg::CFG_ACTIVE_RANGES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int backlog;
	int beats_checked;

	// Contents last written, used only to aim lookups at real entries.
	logic [CODE_W-1:0] shadow_first [MAX_RANGES];
	logic [CODE_W-1:0] shadow_last [MAX_RANGES];
	logic [CODE_W-1:0] shadow_sparse [MAX_SPARSE];
	bit full_loaded = 1'b0;
	bit pressure_done = 1'b0;

	int src_idle_pct = 18;
	int dst_idle_pct = 69;
	int hold_epoch = 0;
	int served_epoch = 0;
	int cycle_count = 0;
	int n_lookups = 0;
	int n_table_writes = 0;
	int n_ignored = 0;
	int n_reg_writes = 0;
	int n_phases = 0;
	int bulk_writes = 0;

	glyph_index_lookup_core #(
		.MAX_RANGES(MAX_RANGES),
		.MAX_SPARSE(MAX_SPARSE)
	) DUT (.*);

	glyph_lookup_checker #(
		.MAX_RANGES(MAX_RANGES),
		.MAX_SPARSE(MAX_SPARSE)
	) scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (served_epoch != hold_epoch) begin
				served_epoch = hold_epoch;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < dst_idle_pct);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
		$display("glyph_index_lookup_core test failed");
		$finish;
	end

	task automatic send_req(input logic [REQ_W-1:0] rq, input int sl, input int cp,
			input int rl);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		slot <= SLOT_W'(sl);
		code_point <= CODE_W'(cp);
		range_last <= CODE_W'(rl);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (rq == gil_pkg::REQ_LOOKUP) begin
			n_lookups++;
		end else if (rq == gil_pkg::REQ_WR_RANGE && sl < MAX_RANGES) begin
			shadow_first[sl] = CODE_W'(cp);
			shadow_last[sl] = CODE_W'(rl);
			n_table_writes++;
		end else if (rq == gil_pkg::REQ_WR_SPARSE && sl < MAX_SPARSE) begin
			shadow_sparse[sl] = CODE_W'(cp);
			n_table_writes++;
		end else begin
			n_ignored++;
		end
	endtask

	// The two count values carry random bits above each register's width.
	task automatic set_registers(input int nr_val, input int ns_val, input int base_val);
		logic [CFG_IDX_W-1:0] ids [3];
		logic [CFG_DATA_W-1:0] vals [3];
		int k;
		ids[0] = gil_pkg::CFG_ACTIVE_RANGES;
		ids[1] = gil_pkg::CFG_ACTIVE_SPARSE;
		ids[2] = gil_pkg::CFG_RANGE_GLYPH_TOTAL;
		vals[0] = CFG_DATA_W'(($urandom << AR_W) | nr_val);
		vals[1] = CFG_DATA_W'(($urandom << AS_W) | ns_val);
		vals[2] = CFG_DATA_W'(base_val);
		for (k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= ids[k];
			cfg_data <= vals[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			n_reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// Wait until every lookup is answered and trailing writes have drained.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Ascending, non-overlapping ranges with some single-code and reversed
	// ones, and strictly ascending sparse codes.
	task automatic load_tables(input int nr, input int ns);
		int span, f, l, t, k, shape;
		if (nr > 0) begin
			span = CODE_SPACE / nr;
			for (k = 0; k < nr; k++) begin
				f = k * span + $urandom_range(span / 2);
				l = f + $urandom_range(span / 2 - 1);
				shape = $urandom_range(7);
				if (shape == 0) begin
					t = f;
					f = l;
					l = t;
				end else if (shape == 1) begin
					l = f;
				end
				send_req(gil_pkg::REQ_WR_RANGE, k, f, l);
			end
		end
		if (ns > 0) begin
			span = CODE_SPACE / ns;
			for (k = 0; k < ns; k++)
				send_req(gil_pkg::REQ_WR_SPARSE, k, k * span + $urandom_range(span - 1),
					$urandom);
		end
	endtask

	function automatic int pick_code(input int nr, input int ns);
		int sel, k, v;
		sel = $urandom_range(99);
		if (sel < 35 && nr > 0) begin
			k = $urandom_range(nr - 1);
			return $urandom_range(shadow_last[k], shadow_first[k]);
		end
		if (sel < 65 && ns > 0)
			return shadow_sparse[$urandom_range(ns - 1)];
		if (sel < 80 && ns > 0) begin
			v = shadow_sparse[$urandom_range(ns - 1)];
			v = $urandom_range(1) ? v + 1 : v - 1;
			return v & CODE_TOP;
		end
		if (sel < 85)
			return $urandom_range(1) ? CODE_TOP : 0;
		return $urandom_range(CODE_TOP);
	endfunction

	task automatic send_noise();
		case ($urandom_range(2))
			0: send_req(REQ_UNUSED, $urandom_range(1023), $urandom, $urandom);
			1: send_req(gil_pkg::REQ_WR_RANGE, $urandom_range(1023), $urandom, $urandom);
			default: send_req(gil_pkg::REQ_WR_SPARSE, $urandom_range(1023), $urandom,
				$urandom);
		endcase
	endtask

	task automatic run_phase(input bit big);
		int nr_cfg, ns_cfg, nr, ns, base, count, progress, writes_prior;
		n_phases++;
		progress = n_lookups + n_table_writes - bulk_writes;
		if (progress < 450) begin
			src_idle_pct = 18;
			dst_idle_pct = 69;
		end else if (progress < 900) begin
			src_idle_pct = 69;
			dst_idle_pct = 18;
		end else begin
			src_idle_pct = 0;
			dst_idle_pct = 0;
		end
		if (big && !full_loaded) begin
			// Counts above the table depth, which must saturate.
			nr_cfg = $urandom_range(127, MAX_RANGES + 1);
			ns_cfg = $urandom_range(2047, MAX_SPARSE + 1);
		end else if (big) begin
			nr_cfg = MAX_RANGES;
			ns_cfg = MAX_SPARSE;
		end else begin
			nr_cfg = $urandom_range(8);
			ns_cfg = $urandom_range(40);
		end
		nr = (nr_cfg > MAX_RANGES) ? MAX_RANGES : nr_cfg;
		ns = (ns_cfg > MAX_SPARSE) ? MAX_SPARSE : ns_cfg;
		case ($urandom_range(3))
			0: base = 0;
			1: base = GLYPH_TOP;
			2: base = GLYPH_TOP - $urandom_range(60);
			default: base = $urandom_range(GLYPH_TOP);
		endcase
		set_registers(nr_cfg, ns_cfg, base);
		if (big && !full_loaded) begin
			writes_prior = n_table_writes;
			load_tables(MAX_RANGES, MAX_SPARSE);
			bulk_writes += n_table_writes - writes_prior;
			full_loaded = 1'b1;
		end else if (!big) begin
			load_tables(nr, ns);
		end
		if (src_idle_pct == 0 && !pressure_done) begin
			hold_epoch++;
			pressure_done = 1'b1;
		end
		count = big ? $urandom_range(70, 40) : $urandom_range(60, 20);
		repeat (count) begin
			if ($urandom_range(99) < 10)
				send_noise();
			else
				send_req(gil_pkg::REQ_LOOKUP, $urandom_range(1023), pick_code(nr, ns),
					$urandom);
		end
		quiesce();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty configuration: nothing can be found, ignored requests give
		// no beat, and the last sparse slot is still writable.
		send_req(gil_pkg::REQ_LOOKUP, 0, 0, 0);
		send_req(gil_pkg::REQ_LOOKUP, 1023, CODE_TOP, CODE_TOP);
		send_req(REQ_UNUSED, 1023, CODE_TOP, CODE_TOP);
		send_req(gil_pkg::REQ_WR_RANGE, 1023, 5, 9);
		send_req(gil_pkg::REQ_WR_SPARSE, 1023, CODE_TOP, 0);
		quiesce();

		// Three ranges, the middle one reversed, and four sparse codes with a
		// base close to the top so sparse indexes wrap.
		set_registers(3, 4, GLYPH_TOP - 1);
		send_req(gil_pkg::REQ_WR_RANGE, 0, 'h20, 'h7E);
		send_req(gil_pkg::REQ_WR_RANGE, 1, 'h300, 'h100);
		send_req(gil_pkg::REQ_WR_RANGE, 2, 'h1FFF00, CODE_TOP);
		send_req(gil_pkg::REQ_WR_SPARSE, 0, 0, 0);
		send_req(gil_pkg::REQ_WR_SPARSE, 1, 5, 0);
		send_req(gil_pkg::REQ_WR_SPARSE, 2, 'h200, 0);
		send_req(gil_pkg::REQ_WR_SPARSE, 3, 'h10000, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h20, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h7E, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h200, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, CODE_TOP, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 0, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 5, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h10000, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h1F, 0);
		send_req(gil_pkg::REQ_LOOKUP, 0, 'h7F, 0);
		quiesce();

		while (n_lookups + n_table_writes - bulk_writes < RANDOM_ITEMS)
			run_phase(n_phases == 3 || n_phases == 12);

		$display(
			"Ran %0d phases: %0d lookups, %0d table writes, %0d register writes, %0d ignored.",
			n_phases, n_lookups, n_table_writes, n_reg_writes, n_ignored);
		$display("Compared %0d result beats, with tables up to full depth and counts past it.",
			beats_checked);
		if (mismatches == 0 && backlog == 0)
			$display("glyph_index_lookup_core test passed");
		else
			$display("glyph_index_lookup_core test failed");
		$finish;
	end

endmodule
